/* design/pgw_pkg.sv */
// Shared types, constants and helpers for the four-level page table walker.
// No dependencies; used by pgw_store and four_level_page_table_walker_core.
package pgw_pkg;

  localparam int TABLE_PAGES = 64;
  localparam int IDX_W       = 9;
  localparam int ENTRIES     = 512;
  localparam int PAGE_W      = $clog2(TABLE_PAGES);
  localparam int ADDR_W      = PAGE_W + IDX_W;
  localparam int DEPTH       = TABLE_PAGES * ENTRIES;
  // pool pointer must hold TABLE_PAGES itself and the 7-bit register value
  localparam int NFP_W       = (PAGE_W + 1 > 7) ? PAGE_W + 1 : 7;
  localparam int CMP_W       = 13;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [CMP_W-1:0]  TP_CMP    = CMP_W'(TABLE_PAGES);
  localparam logic [39:0]       TP_PG     = 40'(TABLE_PAGES);

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_MAP    = 2'd1;
  localparam logic [1:0] MODE_UNMAP  = 2'd2;
  localparam logic [1:0] MODE_NOP    = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED  = 2'd2;
  localparam logic [1:0] ST_OUTSIDE    = 2'd3;

  localparam logic [1:0] CFG_ROOT       = 2'd0;
  localparam logic [1:0] CFG_FIRST_FREE = 2'd1;
  localparam logic [1:0] CFG_BASE       = 2'd2;

  localparam logic [11:0] LINK_FLAGS = 12'h007;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       wdata;
  } mem_req_t;

  // table index for a walk level: 47:39, 38:30, 29:21, 20:12
  function automatic logic [IDX_W-1:0] vidx(input logic [47:0] va, input logic [1:0] lvl);
    logic [IDX_W-1:0] r;
    case (lvl)
      2'd0:    r = va[47:39];
      2'd1:    r = va[38:30];
      2'd2:    r = va[29:21];
      default: r = va[20:12];
    endcase
    return r;
  endfunction

endpackage

/* design/pgw_store.sv */
// Table store: single-port memory with registered read data and a
// clearing sweep after reset. Depends on pgw_pkg.
module pgw_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pgw_pkg::mem_req_t           req,
  output logic [63:0]                 rdata,
  output logic                        clr_busy
);

  logic [63:0]                 mem [pgw_pkg::DEPTH];
  logic [63:0]                 rdata_r;
  logic [pgw_pkg::ADDR_W-1:0]  clr_idx_r;
  logic                        clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == pgw_pkg::LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (req.we) begin
      mem[req.addr] <= req.wdata;
    end else begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata    = rdata_r;
  assign clr_busy = clr_busy_r;

endmodule

/* design/four_level_page_table_walker_core.sv */
// Four-level page table walker: sequencer, config registers, result register.
// Depends on pgw_pkg and pgw_store.
//
//  channel | signals                                     | moves
//  --------+---------------------------------------------+---------------------------
//  in      | in_valid/in_ready, mode vaddr paddr flags   | one walk request item
//  out     | out_valid/out_ready, phys_addr status inv.  | one result item per request
//  cfg     | cfg_we, cfg_index, cfg_wdata                | register write, no wait
//
// Walk: each level is a read issue (S_RD), then a check of the
// registered read data (S_EVAL) on the single table store port; a link allocation
// writes during the check state. A lookup checks all four levels; map and
// unmap check three and then write the leaf (S_LEAF); a bad root or unused
// mode goes straight to S_FIN. in_ready returns in the same cycle that
// out_valid rises, as S_FIN loads the output register. Early exits are shorter.
// Reset: the store is swept to zero, one entry a cycle, over all TABLE_PAGES*512
// entries (32768 at 64 pages); in_ready stays low meanwhile, cfg writes are taken.
// Stalls: one item at a time. A finished result waits in the output register,
// and the next item may be accepted and walked while it waits.
module four_level_page_table_walker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [47:0] in_vaddr,
  input  logic [51:0] in_paddr,
  input  logic [63:0] in_flags,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [51:0] out_phys_addr,
  output logic [1:0]  out_status,
  output logic        out_invalidate,
  output logic [47:0] out_invalidate_vaddr,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [51:0] cfg_wdata
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_LEAF  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  // control
  logic [2:0]                 state_r, state_nxt;
  logic [1:0]                 lvl_r, lvl_nxt;
  logic [pgw_pkg::NFP_W-1:0]  nfp_r, nfp_nxt;
  logic [5:0]                 root_r, root_nxt;
  logic [39:0]                base_r, base_nxt;      // table_base_phys[51:12]
  logic                       out_valid_r, out_valid_nxt;

  // payload
  logic [1:0]                 mode_r, mode_nxt;
  logic [47:0]                va_r, va_nxt;
  logic [51:0]                pa_r, pa_nxt;
  logic [63:0]                fl_r, fl_nxt;
  logic [pgw_pkg::PAGE_W-1:0] page_r, page_nxt;
  logic [1:0]                 st_r, st_nxt;
  logic [51:0]                phys_r, phys_nxt;
  logic                       inv_r, inv_nxt;
  logic [51:0]                o_phys_r, o_phys_nxt;
  logic [1:0]                 o_st_r, o_st_nxt;
  logic                       o_inv_r, o_inv_nxt;
  logic [47:0]                o_iva_r, o_iva_nxt;

  pgw_pkg::mem_req_t          mem_req;
  logic [63:0]                rdata;
  logic                       clr_busy;

  // link check / allocation datapath (shared across levels)
  logic [40:0]                diff;
  logic                       link_outside;
  logic [pgw_pkg::CMP_W-1:0]  root_ext, nfp_ext;
  logic                       root_outside, pool_empty;
  logic [39:0]                new_link;
  logic                       next_is_leaf;

  pgw_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rdata    (rdata),
    .clr_busy (clr_busy)
  );

  assign diff         = {1'b0, rdata[51:12]} - {1'b0, base_r};
  assign link_outside = diff[40] || (diff[39:0] >= pgw_pkg::TP_PG);
  assign root_ext     = pgw_pkg::CMP_W'(root_r);
  assign nfp_ext      = pgw_pkg::CMP_W'(nfp_r);
  assign root_outside = root_ext >= pgw_pkg::TP_CMP;
  assign pool_empty   = nfp_ext >= pgw_pkg::TP_CMP;
  assign new_link     = base_r + 40'(nfp_r);        // wraps at 52 bits
  // map and unmap write the leaf straight away, lookup reads it
  assign next_is_leaf = (lvl_r == 2'd2) && (mode_r != pgw_pkg::MODE_LOOKUP);

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    nfp_nxt       = nfp_r;
    root_nxt      = root_r;
    base_nxt      = base_r;
    out_valid_nxt = out_valid_r;
    mode_nxt      = mode_r;
    va_nxt        = va_r;
    pa_nxt        = pa_r;
    fl_nxt        = fl_r;
    page_nxt      = page_r;
    st_nxt        = st_r;
    phys_nxt      = phys_r;
    inv_nxt       = inv_r;
    o_phys_nxt    = o_phys_r;
    o_st_nxt      = o_st_r;
    o_inv_nxt     = o_inv_r;
    o_iva_nxt     = o_iva_r;

    mem_req.we    = 1'b0;
    mem_req.addr  = {page_r, pgw_pkg::vidx(va_r, lvl_r)};
    mem_req.wdata = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        if (!clr_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_mode;
          va_nxt   = in_vaddr;
          pa_nxt   = in_paddr;
          fl_nxt   = in_flags;
          st_nxt   = pgw_pkg::ST_OK;
          phys_nxt = '0;
          inv_nxt  = 1'b0;
          lvl_nxt  = 2'd0;
          page_nxt = root_ext[pgw_pkg::PAGE_W-1:0];
          if (in_mode == pgw_pkg::MODE_NOP) begin
            state_nxt = S_FIN;
          end else if (root_outside) begin
            st_nxt    = pgw_pkg::ST_OUTSIDE;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (lvl_r == 2'd3) begin
          // lookup leaf
          if (rdata[0]) begin
            phys_nxt = {rdata[51:12], va_r[11:0]};
          end else begin
            st_nxt = pgw_pkg::ST_NOT_MAPPED;
          end
          state_nxt = S_FIN;
        end else if (rdata[0]) begin
          if (link_outside) begin
            st_nxt    = pgw_pkg::ST_OUTSIDE;
            state_nxt = S_FIN;
          end else begin
            page_nxt  = diff[pgw_pkg::PAGE_W-1:0];
            lvl_nxt   = lvl_r + 2'd1;
            state_nxt = next_is_leaf ? S_LEAF : S_RD;
          end
        end else if (mode_r != pgw_pkg::MODE_MAP) begin
          st_nxt    = pgw_pkg::ST_NOT_MAPPED;
          state_nxt = S_FIN;
        end else if (pool_empty) begin
          st_nxt    = pgw_pkg::ST_EXHAUSTED;
          state_nxt = S_FIN;
        end else begin
          // allocate a table from the pool and link it
          mem_req.we    = 1'b1;
          mem_req.wdata = {12'b0, new_link, pgw_pkg::LINK_FLAGS};
          page_nxt      = nfp_r[pgw_pkg::PAGE_W-1:0];
          nfp_nxt       = nfp_r + 1'b1;
          lvl_nxt       = lvl_r + 2'd1;
          state_nxt     = next_is_leaf ? S_LEAF : S_RD;
        end
      end
      S_LEAF: begin
        mem_req.we = 1'b1;
        if (mode_r == pgw_pkg::MODE_MAP) begin
          mem_req.wdata = {12'b0, pa_r[51:12], 12'b0} | fl_r | 64'd1;
        end
        inv_nxt   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          o_phys_nxt    = phys_r;
          o_st_nxt      = st_r;
          o_inv_nxt     = inv_r;
          o_iva_nxt     = inv_r ? va_r : 48'd0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        pgw_pkg::CFG_ROOT:       root_nxt = cfg_wdata[5:0];
        pgw_pkg::CFG_FIRST_FREE: nfp_nxt  = pgw_pkg::NFP_W'(cfg_wdata[6:0]);
        pgw_pkg::CFG_BASE:       base_nxt = cfg_wdata[51:12];
        default:                 ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      lvl_r       <= 2'd0;
      nfp_r       <= pgw_pkg::NFP_W'(1);
      root_r      <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      nfp_r       <= nfp_nxt;
      root_r      <= root_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    va_r     <= va_nxt;
    pa_r     <= pa_nxt;
    fl_r     <= fl_nxt;
    page_r   <= page_nxt;
    st_r     <= st_nxt;
    phys_r   <= phys_nxt;
    inv_r    <= inv_nxt;
    o_phys_r <= o_phys_nxt;
    o_st_r   <= o_st_nxt;
    o_inv_r  <= o_inv_nxt;
    o_iva_r  <= o_iva_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_phys_addr        = o_phys_r;
  assign out_status           = o_st_r;
  assign out_invalidate       = o_inv_r;
  assign out_invalidate_vaddr = o_iva_r;

  // one walk at a time: after an acceptance the port closes
  a_one_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while a walk is in flight");

  // no table store write while the clearing sweep runs
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !mem_req.we)
    else $error("table store written during clearing sweep");

  // an invalidate is only raised for a completed map or unmap
  a_inv_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalidate) |-> (out_status == pgw_pkg::ST_OK && out_phys_addr == 52'd0))
    else $error("invalidate with failed status or translation");

  // the pool pointer only moves by one allocation per cycle, or by a cfg write
  a_pool_bump: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> (nfp_r == $past(nfp_r) || nfp_r == $past(nfp_r) + 1'b1))
    else $error("pool pointer jumped");

endmodule
